// ===== hdl/mm2fb_pkg.sv =====
// mm2fb_pkg: address table and function code constants for the MM2 frame builder.
// No dependencies.
package mm2fb_pkg;

    localparam logic [7:0] SpeedMask = 8'h55;
    localparam logic [7:0] CodeClashOff = 8'h22;
    localparam logic [7:0] CodeClashOn = 8'h88;
    localparam logic [7:0] OnBit = 8'h80;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [7:0] addr;
        logic [1:0] fld;
        logic [7:0] speed;
        logic       half;
    } t_frame;

    localparam t_byte AddrTable [256] = '{
        8'h03,8'h01,8'h0C,8'h0F,8'h0D,8'h04,8'h07,8'h05,8'h30,8'h33,8'h31,8'h3C,8'h3F,8'h3D,8'h34,8'h37,
        8'h35,8'h10,8'h13,8'h11,8'h1C,8'h1F,8'h1D,8'h14,8'h17,8'h15,8'hC0,8'hC3,8'hC1,8'hCC,8'hCF,8'hCD,
        8'hC4,8'hC7,8'hC5,8'hF0,8'hF3,8'hF1,8'hFC,8'hFF,8'hFD,8'hD4,8'hD7,8'hD5,8'hD0,8'hD3,8'hD1,8'hDC,
        8'hDF,8'hDD,8'hF4,8'hF7,8'hF5,8'h40,8'h43,8'h41,8'h4C,8'h4F,8'h4D,8'h44,8'h47,8'h45,8'h70,8'h73,
        8'h71,8'h7C,8'h7F,8'h7D,8'h74,8'h77,8'h75,8'h50,8'h53,8'h51,8'h5C,8'h5F,8'h5D,8'h54,8'h57,8'h55,
        8'h02,8'h06,8'hE9,8'h0E,8'h12,8'h16,8'h1A,8'h1E,8'h22,8'h26,8'h2A,8'h2E,8'h32,8'h36,8'h3A,8'h3E,
        8'h42,8'h46,8'h4A,8'h4E,8'h52,8'h56,8'h5A,8'h5E,8'h62,8'h66,8'h6A,8'h6E,8'h72,8'h76,8'h7A,8'h7E,
        8'h82,8'h86,8'h8A,8'h8E,8'h92,8'h96,8'h9A,8'h9E,8'hA2,8'hA6,8'hF9,8'hAE,8'hB2,8'hB6,8'hBA,8'hBE,
        8'hC2,8'hC6,8'hCA,8'hCE,8'hD2,8'hD6,8'hDA,8'hDE,8'hE2,8'hE6,8'hEA,8'hEE,8'hF2,8'hF6,8'hFA,8'hFE,
        8'h08,8'h18,8'h28,8'h38,8'h48,8'h58,8'h68,8'h78,8'h88,8'h98,8'hA8,8'hB8,8'hC8,8'hD8,8'hE8,8'hF8,
        8'h0B,8'h1B,8'h2B,8'h3B,8'h4B,8'h5B,8'h6B,8'h7B,8'h8B,8'h9B,8'hAB,8'hBB,8'hCB,8'hDB,8'hEB,8'hFB,
        8'h09,8'h19,8'h29,8'h39,8'h49,8'h59,8'h69,8'h79,8'h89,8'h99,8'hA9,8'hB9,8'hC9,8'hD9,8'h0A,8'hAA,
        8'h20,8'h60,8'hA0,8'hE0,8'h23,8'h63,8'hA3,8'hE3,8'h21,8'h61,8'hA1,8'hE1,8'h2C,8'h6C,8'hAC,8'hEC,
        8'h2F,8'h6F,8'hAF,8'hEF,8'h2D,8'h6D,8'hAD,8'hED,8'h24,8'h64,8'hA4,8'hE4,8'h27,8'h67,8'hA7,8'hE7,
        8'h25,8'h65,8'hA5,8'hE5,8'h80,8'h83,8'h81,8'h8C,8'h8F,8'h8D,8'h84,8'h87,8'h85,8'hB0,8'hB3,8'hB1,
        8'hBC,8'hBF,8'hBD,8'hB4,8'hB7,8'hB5,8'h90,8'h93,8'h91,8'h9C,8'h9F,8'h9D,8'h94,8'h97,8'h95,8'h00
    };

    localparam t_byte ClashOff [4] = '{8'h05, 8'h10, 8'h11, 8'h14};
    localparam t_byte ClashOn  [4] = '{8'h50, 8'h51, 8'h54, 8'h55};
    localparam t_byte FuncCode [4] = '{8'h0A, 8'h20, 8'h28, 8'h2A};

    // Inverse of addr_encode over AddrTable's first 255 entries, first match wins; 0 if absent.
    function automatic t_byte addr_decode(input t_byte code);
        t_byte r;
        r = 8'd0;
        for (int i = 254; i >= 0; i--) begin
            if (AddrTable[i] == code) r = 8'(i + 1);
        end
        return r;
    endfunction

    function automatic t_byte addr_encode(input t_byte v);
        return (v == 8'd0) ? 8'd0 : AddrTable[8'(v - 8'd1)];
    endfunction

    function automatic t_byte func_encode(input logic [1:0] fidx, input t_byte speed,
                                          input logic on);
        if (!on && speed == ClashOff[fidx]) return CodeClashOff;
        if (on && speed == ClashOn[fidx]) return CodeClashOn;
        return FuncCode[fidx] | (on ? OnBit : 8'h00);
    endfunction

endpackage

// ===== hdl/mm2fb_encode.sv =====
// mm2fb_encode: combinational frame mapping for one request.
// Uses mm2fb_pkg.
module mm2fb_encode (
    input  logic [7:0]       i_address_code,
    input  logic [7:0]       i_speed_first,
    input  logic [7:0]       i_speed_second,
    input  logic             i_has_second_speed,
    input  logic [5:0]       i_func_number,
    input  logic [31:0]      i_func_bits,
    input  logic             i_half_rate,
    output mm2fb_pkg::t_frame o_frame
);
    import mm2fb_pkg::*;

    logic [7:0] speed, masked, dec, addr;
    logic [5:0] fm2, bitpos;
    logic [1:0] fld;
    logic       f0, on;

    always_comb begin
        f0     = i_func_bits[0];
        fld    = f0 ? 2'd3 : 2'd0;
        speed  = i_speed_first;
        addr   = i_address_code;
        fm2    = 6'(i_func_number - 6'd2);
        bitpos = 6'(i_func_number - 6'd1);
        on     = (bitpos < 6'd32) ? i_func_bits[bitpos[4:0]] : 1'b0;
        masked = 8'd0;
        dec    = 8'd0;
        if (i_has_second_speed) begin
            speed = i_speed_second;
            if (i_speed_first != i_speed_second) fld = f0 ? 2'd2 : 2'd1;
        end
        masked = speed & SpeedMask;
        if (i_func_number > 6'd1) begin
            if (i_func_number >= 6'd6) begin
                dec   = 8'(addr_decode(i_address_code) + {4'd0, fm2[5:2]});
                addr  = addr_encode(dec);
                speed = func_encode(fm2[1:0], 8'd0, on);
            end else begin
                speed = masked | func_encode(fm2[1:0], masked, on);
            end
        end
        o_frame = '{addr: addr, fld: fld, speed: speed, half: i_half_rate};
    end
endmodule

// ===== hdl/mm2_frame_builder.sv =====
// mm2_frame_builder: top level, input register, encoder, output register with skid.
// Uses mm2fb_pkg and mm2fb_encode.
// One frame per accepted transaction, registered in the input and then the output
// register; one transaction per cycle when not stalled; the address table lookup
// sits between them. Transactions with power off are dropped and give no frame.
module mm2_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_address_code,
    input  logic [7:0]  i_speed_first,
    input  logic [7:0]  i_speed_second,
    input  logic        i_has_second_speed,
    input  logic [5:0]  i_func_number,
    input  logic [31:0] i_func_bits,
    input  logic        i_half_rate,
    input  logic        i_power_on,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_frame_address,
    output logic [1:0]  o_frame_function,
    output logic [7:0]  o_frame_speed,
    output logic        o_frame_half_rate
);
    import mm2fb_pkg::*;

    logic        r_in_v;
    logic [7:0]  r_addr, r_sp1, r_sp2;
    logic        r_has2, r_half;
    logic [5:0]  r_fn;
    logic [31:0] r_fb;
    logic        r_out_v, r_skid_v;
    t_frame      r_out, r_skid, w_frame;
    logic        in_take, out_free;

    mm2fb_encode u_enc (
        .i_address_code(r_addr), .i_speed_first(r_sp1), .i_speed_second(r_sp2),
        .i_has_second_speed(r_has2), .i_func_number(r_fn), .i_func_bits(r_fb),
        .i_half_rate(r_half), .o_frame(w_frame)
    );

    assign o_stall  = r_skid_v;
    assign in_take  = i_valid && !r_skid_v;
    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_v) begin
                    r_out    <= r_skid;
                    r_out_v  <= 1'b1;
                    r_skid_v <= 1'b0;
                end else begin
                    r_out   <= w_frame;
                    r_out_v <= r_in_v;
                end
            end else if (r_in_v && !r_skid_v) begin
                r_skid   <= w_frame;
                r_skid_v <= 1'b1;
            end
            if (!r_skid_v) begin
                r_in_v <= in_take && i_power_on;
                r_addr <= i_address_code;
                r_sp1  <= i_speed_first;
                r_sp2  <= i_speed_second;
                r_has2 <= i_has_second_speed;
                r_fn   <= i_func_number;
                r_fb   <= i_func_bits;
                r_half <= i_half_rate;
            end else if (out_free) begin
                r_in_v <= r_in_v;
            end
        end
    end

    assign o_valid           = r_out_v;
    assign o_frame_address   = r_out.addr;
    assign o_frame_function  = r_out.fld;
    assign o_frame_speed     = r_out.speed;
    assign o_frame_half_rate = r_out.half;
endmodule

// ===== hdl/mm2fb_checker.sv =====
// mm2fb_checker: port-level assertions for mm2_frame_builder, bound to the top.
// Depends on mm2_frame_builder ports only.
module mm2fb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_frame_address,
    input logic [1:0] o_frame_function,
    input logic [7:0] o_frame_speed
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid) else $error("result dropped while stalled");
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_frame_address) && $stable(o_frame_speed)
        && $stable(o_frame_function)) else $error("stalled result changed");
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid) else $error("input stalled with no result waiting");
    a_stall_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall && !i_stall |=> !o_stall) else $error("skid not drained");
endmodule

bind mm2_frame_builder mm2fb_checker u_chk (.*);
